// ----- design/gidfe_pkg.sv -----
`default_nettype none

package gidfe_pkg;

  // Default number of identifier characters kept per frame.
  localparam int MAX_ID_LEN_DEF = 11;

  // Fixed frame words.
  localparam logic [7:0] DETECT_WORD = 8'hA5;
  localparam logic [7:0] END_WORD    = 8'hD5;
  localparam logic [7:0] PAD_WORD    = 8'h00;
  localparam logic [7:0] TERM_CHAR   = 8'h00;

  // Sequencer states: collecting characters, then one state per frame section.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SYNC,
    ST_ZERO,
    ST_CSUM,
    ST_LEN,
    ST_CHARS,
    ST_PAD0,
    ST_TAIL,
    ST_PAD1
  } state_t;

endpackage

`default_nettype wire

// ----- design/gidfe_ram.sv -----
`default_nettype none

module gidfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 11,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/game_id_frame_encoder.sv -----
// Identifier frame encoder.
// The input channel (in_valid, in_stall, id_char) takes one character word per
// cycle while the block is collecting. Non-zero characters are stored, up to
// MAX_ID_LEN of them; later ones are dropped until a zero character arrives.
// A zero character ends the identifier and starts a frame on the output
// channel (out_valid, out_stall, frame_byte, frame_end): 0xA5, 0x00, checksum,
// length, the stored characters, 0x00, 0xD5, 0x00, with frame_end set on the
// last word. The frame is length+7 words long.
// After the terminator is taken the sequencer enters its first frame state,
// which loads 0xA5 into the output register; the sequencer then hands one
// word per cycle to the output register while the receiver does not stall.
// A stall holds the output word and freezes the sequencer. in_stall stays high
// from the terminator until the final word has been loaded into the output
// register; characters are taken again while that final word still waits.
// The checksum is the negated 8-bit sum of the length, the running character
// sum and 0xD5.
// Synchronous reset empties the character store and drops any pending word.
`default_nettype none

module game_id_frame_encoder #(
  parameter int MAX_ID_LEN = gidfe_pkg::MAX_ID_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] id_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] frame_byte,
  output logic            frame_end
);

  localparam int CNT_W = $clog2(MAX_ID_LEN + 1);
  localparam int IDX_W = (MAX_ID_LEN > 1) ? $clog2(MAX_ID_LEN) : 1;

  gidfe_pkg::state_t state, state_next;

  logic [CNT_W-1:0] char_count;
  logic [7:0]       running_sum;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic [7:0]       rd_data;

  logic       load_ok;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic       char_take;
  logic       term_take;
  logic       last_char;
  logic [7:0] sum_total;
  logic [7:0] checksum;

  // The output register can take a new word when empty or being drained.
  assign load_ok = !out_valid || !out_stall;

  assign char_take = (state == gidfe_pkg::ST_IDLE) && in_valid &&
                     (id_char != gidfe_pkg::TERM_CHAR) &&
                     (char_count < CNT_W'(MAX_ID_LEN));
  assign term_take = (state == gidfe_pkg::ST_IDLE) && in_valid &&
                     (id_char == gidfe_pkg::TERM_CHAR);

  assign last_char = ((CNT_W'(rd_idx) + CNT_W'(1)) == char_count);

  // Checksum covers length, characters and the three trailing words.
  assign sum_total = 8'(char_count) + running_sum + gidfe_pkg::END_WORD;
  assign checksum  = 8'(0) - sum_total;

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      gidfe_pkg::ST_IDLE: begin
        if (term_take) state_next = gidfe_pkg::ST_SYNC;
      end
      gidfe_pkg::ST_SYNC: begin
        if (load_ok) state_next = gidfe_pkg::ST_ZERO;
      end
      gidfe_pkg::ST_ZERO: begin
        if (load_ok) state_next = gidfe_pkg::ST_CSUM;
      end
      gidfe_pkg::ST_CSUM: begin
        if (load_ok) state_next = gidfe_pkg::ST_LEN;
      end
      gidfe_pkg::ST_LEN: begin
        if (load_ok) begin
          state_next = (char_count == '0) ? gidfe_pkg::ST_PAD0 : gidfe_pkg::ST_CHARS;
        end
      end
      gidfe_pkg::ST_CHARS: begin
        if (load_ok && last_char) state_next = gidfe_pkg::ST_PAD0;
      end
      gidfe_pkg::ST_PAD0: begin
        if (load_ok) state_next = gidfe_pkg::ST_TAIL;
      end
      gidfe_pkg::ST_TAIL: begin
        if (load_ok) state_next = gidfe_pkg::ST_PAD1;
      end
      gidfe_pkg::ST_PAD1: begin
        if (load_ok) state_next = gidfe_pkg::ST_IDLE;
      end
      default: state_next = gidfe_pkg::ST_IDLE;
    endcase
  end

  // Word selection and handshake outputs of the sequencer.
  always_comb begin
    emit        = 1'b0;
    emit_byte   = gidfe_pkg::PAD_WORD;
    emit_last   = 1'b0;
    in_stall    = 1'b1;
    rd_idx_next = rd_idx;
    case (state)
      gidfe_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        rd_idx_next = '0;
      end
      gidfe_pkg::ST_SYNC: begin
        emit      = load_ok;
        emit_byte = gidfe_pkg::DETECT_WORD;
      end
      gidfe_pkg::ST_ZERO: begin
        emit      = load_ok;
        emit_byte = gidfe_pkg::PAD_WORD;
      end
      gidfe_pkg::ST_CSUM: begin
        emit      = load_ok;
        emit_byte = checksum;
      end
      gidfe_pkg::ST_LEN: begin
        emit      = load_ok;
        emit_byte = 8'(char_count);
      end
      gidfe_pkg::ST_CHARS: begin
        emit      = load_ok;
        emit_byte = rd_data;
        if (load_ok) rd_idx_next = rd_idx + IDX_W'(1);
      end
      gidfe_pkg::ST_PAD0: begin
        emit      = load_ok;
        emit_byte = gidfe_pkg::PAD_WORD;
      end
      gidfe_pkg::ST_TAIL: begin
        emit      = load_ok;
        emit_byte = gidfe_pkg::END_WORD;
      end
      gidfe_pkg::ST_PAD1: begin
        emit      = load_ok;
        emit_byte = gidfe_pkg::PAD_WORD;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Character store; the read address runs one step ahead of rd_idx so that
  // rd_data always holds the entry that rd_idx points at.
  gidfe_ram #(
    .WIDTH(8),
    .DEPTH(MAX_ID_LEN)
  ) u_store (
    .clk  (clk),
    .we   (char_take),
    .waddr(char_count[IDX_W-1:0]),
    .wdata(id_char),
    .raddr(rd_idx_next),
    .rdata(rd_data)
  );

  // Sequencer, counters and running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gidfe_pkg::ST_IDLE;
      char_count  <= '0;
      running_sum <= '0;
      rd_idx      <= '0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
      if (char_take) begin
        char_count  <= char_count + CNT_W'(1);
        running_sum <= running_sum + id_char;
      end else if (state == gidfe_pkg::ST_PAD1 && load_ok) begin
        char_count  <= '0;
        running_sum <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_byte <= emit_byte;
      frame_end  <= emit_last;
    end
  end

endmodule

`default_nettype wire
